@@ hdl/pascal_triangle_unit_core_defines.svh @@
// Assertion macros for the Pascal triangle unit.
// Both macros sample on the rising clock edge and stay quiet while reset is low.
`ifndef PASCAL_TRIANGLE_UNIT_CORE_DEFINES_SVH
`define PASCAL_TRIANGLE_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PTI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define PTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/pti_pkg.sv @@
package pti_pkg;

  localparam int unsigned MAX_ROW = 34;
  localparam int unsigned ROW_W   = 6;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned PROD_W  = VAL_W + ROW_W;
  localparam int unsigned CNT_W   = $clog2(ACC_W);

  // Largest entry of any legal row, C(33,16).
  localparam logic [VAL_W-1:0] VAL_MAX = 31'd1166803110;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_MUL,
    ST_DIV,
    ST_EMIT,
    ST_ZERO
  } pti_state_e;

  typedef struct packed {
    logic load;
    logic init;
    logic mul;
    logic div_step;
    logic emit;
    logic emit_zero;
  } pti_cmd_t;

  typedef struct packed {
    logic bad;
    logic mode;
    logic done;
    logic div_last;
    logic out_free;
  } pti_sts_t;

endpackage

@@ hdl/pascal_triangle_unit_core.sv @@
// Pascal triangle unit: each request names a 1-based row and column and a
// mode. Element mode (req_type 0) returns one value, C(row-1, col-1), or 0
// when the column is zero or beyond the row; row mode (req_type 1) returns
// the row's entries left to right, last_o marking the final one. A row of
// zero or above 34 yields a single 0 with last_o set. Each entry comes from
// the one before by a multiply with (row-1-i) and an exact bit-serial
// division by (i+1); that divider retires one quotient bit per cycle over
// a 40-bit dividend, so one step is a multiply, 40 divide steps, then a
// test or emit. One request is worked at a time: the input stalls from
// acceptance until the last result has been placed in the output
// register, and the next request may then transfer while that result
// still waits for the consumer.
`include "pascal_triangle_unit_core_defines.svh"

module pascal_triangle_unit_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      req_type_i,
  input  logic [pti_pkg::ROW_W-1:0] row_number_i,
  input  logic [pti_pkg::ROW_W-1:0] column_number_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [pti_pkg::VAL_W-1:0] value_o,
  output logic                      last_o
);
  import pti_pkg::*;

  pti_cmd_t cmd;
  pti_sts_t sts;

  // Sequencer: walks check, multiply, divide and emit for one request.
  pti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: request latches, running product, serial divider, output register.
  pti_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .row_number_i    (row_number_i),
    .column_number_i (column_number_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .value_o         (value_o),
    .last_o          (last_o)
  );

  // A transfer in always starts work, so the input must stall next cycle.
  `PTI_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not stalled after transfer")
  // A pending non-final result means its request is still being worked.
  `PTI_ASSERT_NOW(a_mid_row_busy, clk_i, rst_ni, out_valid_o && !last_o, in_stall_o, "new request taken before row finished")
  // No legal entry exceeds the center of row 34.
  `PTI_ASSERT_NOW(a_value_range, clk_i, rst_ni, out_valid_o, value_o <= VAL_MAX, "result out of range")

endmodule

@@ hdl/pti_datapath.sv @@
module pti_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pti_pkg::pti_cmd_t         cmd_i,
  output pti_pkg::pti_sts_t         sts_o,
  input  logic                      req_type_i,
  input  logic [pti_pkg::ROW_W-1:0] row_number_i,
  input  logic [pti_pkg::ROW_W-1:0] column_number_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic [pti_pkg::VAL_W-1:0] value_o,
  output logic                      last_o
);
  import pti_pkg::*;

  logic              mode_q;
  logic [ROW_W-1:0]  row_q;
  logic [ROW_W-1:0]  col_q;
  logic [ROW_W-1:0]  i_q;
  logic [VAL_W-1:0]  acc_q;
  logic [ACC_W-1:0]  dq_q;
  logic [ROW_W-1:0]  rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  value_q;
  logic              last_q;

  logic [ROW_W-1:0]  n_idx;
  logic [ROW_W-1:0]  k_idx;
  logic [ROW_W-1:0]  factor;
  logic [ROW_W-1:0]  dvsr;
  logic [PROD_W-1:0] prod;
  logic [ROW_W:0]    trial;
  logic              q_bit;
  logic [ROW_W-1:0]  rem_d;
  logic [ACC_W-1:0]  quo_next;
  logic              div_last;
  logic              out_free;

  assign n_idx  = row_q - ROW_W'(1);
  assign k_idx  = mode_q ? n_idx : (col_q - ROW_W'(1));
  assign factor = n_idx - i_q;
  assign dvsr   = i_q + ROW_W'(1);
  assign prod   = acc_q * factor;

  // One restoring division step: remainder stays below the divisor.
  assign trial    = {rem_q, dq_q[ACC_W-1]};
  assign q_bit    = (trial >= {1'b0, dvsr});
  assign rem_d    = q_bit ? ROW_W'(trial - {1'b0, dvsr}) : trial[ROW_W-1:0];
  assign quo_next = {dq_q[ACC_W-2:0], q_bit};
  assign div_last = (cnt_q == CNT_W'(ACC_W - 1));

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit || cmd_i.emit_zero) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      i_q         <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.load) begin
        mode_q <= req_type_i;
        row_q  <= row_number_i;
        col_q  <= column_number_i;
      end
      if (cmd_i.init) begin
        acc_q <= VAL_W'(1);
        i_q   <= '0;
      end
      if (cmd_i.mul) begin
        cnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (div_last) begin
          acc_q <= quo_next[VAL_W-1:0];
          i_q   <= i_q + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      dq_q  <= ACC_W'(prod);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q  <= quo_next;
      rem_q <= rem_d;
    end
    if (cmd_i.emit) begin
      value_q <= acc_q;
      last_q  <= (i_q == k_idx);
    end else if (cmd_i.emit_zero) begin
      value_q <= '0;
      last_q  <= 1'b1;
    end
  end

  assign sts_o.bad      = (row_q == '0) || (row_q > ROW_W'(MAX_ROW)) ||
                          (!mode_q && ((col_q == '0) || (col_q > row_q)));
  assign sts_o.mode     = mode_q;
  assign sts_o.done     = (i_q == k_idx);
  assign sts_o.div_last = div_last;
  assign sts_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

@@ hdl/pti_ctrl.sv @@
module pti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pti_pkg::pti_sts_t sts_i,
  output pti_pkg::pti_cmd_t cmd_o
);
  import pti_pkg::*;

  pti_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: begin
        if (sts_i.bad) begin
          state_d = ST_ZERO;
        end else if (sts_i.mode) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_TEST;
        end
      end
      ST_TEST:  state_d = sts_i.done ? ST_EMIT : ST_MUL;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) begin
          state_d = sts_i.mode ? ST_EMIT : ST_TEST;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.done ? ST_IDLE : ST_MUL;
        end
      end
      ST_ZERO:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_CHECK: cmd_o.init      = !sts_i.bad;
      ST_TEST:  ;
      ST_MUL:   cmd_o.mul       = 1'b1;
      ST_DIV:   cmd_o.div_step  = 1'b1;
      ST_EMIT:  cmd_o.emit      = sts_i.out_free;
      ST_ZERO:  cmd_o.emit_zero = sts_i.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
